### rtl/mlp_pkg.sv
// ----------------------------------------------------------------------------
// mlp_pkg: shared types and constants for mark label placement
// Beat structs, register indexes, front/back queue entry and back-end state type.
// ----------------------------------------------------------------------------
package mlp_pkg;

    localparam int MaxMarks  = 64;
    localparam int CntW      = 7;
    localparam int IdxW      = 6;
    localparam int QDepth    = 2;
    localparam int QPtrW     = $clog2(QDepth);
    localparam int QCntW     = QPtrW + 1;

    localparam logic [2:0] RegImageWidth   = 3'd0;
    localparam logic [2:0] RegImageHeight  = 3'd1;
    localparam logic [2:0] RegThickness    = 3'd2;
    localparam logic [2:0] RegLabelSize    = 3'd3;
    localparam logic [2:0] RegMarkLimit    = 3'd4;

    localparam logic [2:0] PosNone   = 3'd0;

    typedef struct packed {
        logic        frame_start;
        logic [31:0] box_x;
        logic [31:0] box_y;
        logic [31:0] box_width;
        logic [31:0] box_height;
        logic [63:0] region_identity;
    } item_t;

    typedef struct packed {
        logic [6:0]  mark_number;
        logic        drawn;
        logic [14:0] clip_x;
        logic [14:0] clip_y;
        logic [14:0] clip_width;
        logic [14:0] clip_height;
        logic [4:0]  outline_width;
        logic [2:0]  color_index;
        logic [2:0]  label_position;
        logic [14:0] label_top;
        logic [3:0]  label_scale;
        logic        over_budget;
    } result_t;

    // classified item handed from front to back
    typedef struct packed {
        result_t     res;        // everything but the label
        logic        try_label;
        logic        clear;      // frame start: drop stored labels
        logic [15:0] chip_w;
        logic [15:0] chip_h;
        logic [15:0] cy0;        // y0 - chip_h - 1 (may be negative)
        logic [15:0] cy3;        // y0 + ch - chip_h
        logic [3:0]  fits;       // candidate lies inside image
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_SCAN,
        BK_DONE
    } bk_state_t;

endpackage

### rtl/mlp_ram.sv
// ----------------------------------------------------------------------------
// mlp_ram: generic single port write, single port read RAM
// Registered read data.
// ----------------------------------------------------------------------------
module mlp_ram #(
    parameter int Width = 64,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/mlp_front.sv
// ----------------------------------------------------------------------------
// mlp_front: clips a region, counts marks, sizes the label chip
// One item a cycle while the job queue is not full; results go into the job queue.
// ----------------------------------------------------------------------------
module mlp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  mlp_pkg::item_t    item,
    input  logic [14:0]       image_width,
    input  logic [14:0]       image_height,
    input  logic [4:0]        line_thick,
    input  logic [6:0]        label_size,
    input  logic [6:0]        mark_limit,
    output mlp_pkg::job_t     job
);
    import mlp_pkg::*;

    logic [CntW-1:0] mark_count_reg, mark_count_next;
    logic [CntW-1:0] limit, cur, mark;
    logic signed [33:0] bx, by, x1r, y1r, x0, y0, x1, y1, dw, dh;
    logic [14:0] cw, ch;
    logic drawn, over;
    logic [6:0] lh;
    logic [12:0] lh_x43;
    logic [3:0] scale;
    logic [4:0] thick, outl;
    logic [1:0] digits;
    logic [15:0] chip_w, chip_h;
    logic signed [17:0] c0, c1, c2, c3;
    logic [3:0] fits;

    function automatic logic fit(input logic signed [17:0] y, input logic [15:0] w,
                                 input logic [15:0] h, input logic [14:0] x,
                                 input logic [14:0] iw, input logic [14:0] ih);
        logic ok;
        ok = (y >= 0) && ({3'b0, x} + {2'b0, w} <= {3'b0, iw})
             && (y + $signed({2'b0, h}) <= $signed({3'b0, ih}));
        return ok;
    endfunction

    always_comb
    begin
        limit = (mark_limit > 7'(MaxMarks)) ? 7'(MaxMarks) : mark_limit;
        cur   = item.frame_start ? '0 : mark_count_reg;
        over  = (cur >= limit);
        mark  = cur + 7'd1;
        mark_count_next = mark_count_reg;
        if (take)
        begin
            mark_count_next = over ? cur : mark;
        end

        bx  = 34'(signed'(item.box_x));
        by  = 34'(signed'(item.box_y));
        x1r = bx + 34'(signed'(item.box_width));
        y1r = by + 34'(signed'(item.box_height));
        x0  = (bx < 0) ? '0 : bx;
        y0  = (by < 0) ? '0 : by;
        x1  = (x1r < $signed({19'b0, image_width})) ? x1r : $signed({19'b0, image_width});
        y1  = (y1r < $signed({19'b0, image_height})) ? y1r : $signed({19'b0, image_height});
        dw  = x1 - x0;
        dh  = y1 - y0;
        drawn = (dw > 0) && (dh > 0);
        cw  = drawn ? dw[14:0] : '0;
        ch  = drawn ? dh[14:0] : '0;

        lh     = (label_size > 7'd64) ? 7'd64 : label_size;
        // lh / 6 as lh * 43 / 256, exact over 0..64
        lh_x43 = 13'(lh) * 13'd43;
        scale  = (lh < 7'd12) ? 4'd1 : lh_x43[11:8];
        thick = (line_thick == 5'd0) ? 5'd1 :
                (line_thick > 5'd16) ? 5'd16 : line_thick;
        outl  = thick;
        if ({10'b0, outl} > cw) outl = cw[4:0];
        if ({10'b0, outl} > ch) outl = ch[4:0];

        digits = (mark >= 7'd100) ? 2'd3 : (mark >= 7'd10) ? 2'd2 : 2'd1;
        chip_w = 16'(digits) * 16'(scale) * 16'd3 + 16'd2;
        chip_h = 16'(scale) * 16'd5 + 16'd2;
        c0 = 18'(y0) - 18'(chip_h) - 18'sd1;
        c1 = 18'(y0) + 18'(ch) + 18'sd1;
        c2 = 18'(y0);
        c3 = 18'(y0) + 18'(ch) - 18'(chip_h);
        fits[0] = fit(c0, chip_w, chip_h, cw == 0 ? 15'd0 : x0[14:0], image_width, image_height);
        fits[1] = fit(c1, chip_w, chip_h, x0[14:0], image_width, image_height);
        fits[2] = fit(c2, chip_w, chip_h, x0[14:0], image_width, image_height);
        fits[3] = fit(c3, chip_w, chip_h, x0[14:0], image_width, image_height);

        job = '0;
        job.clear = item.frame_start;
        job.res.color_index = item.region_identity[2:0];
        job.res.label_scale = scale;
        if (over)
        begin
            job.res = '0;
            job.res.over_budget = 1'b1;
        end
        else
        begin
            job.res.mark_number = mark;
            job.res.drawn = drawn;
            if (drawn)
            begin
                job.res.clip_x = x0[14:0];
                job.res.clip_y = y0[14:0];
                job.res.clip_width = cw;
                job.res.clip_height = ch;
                job.res.outline_width = outl;
                job.try_label = (lh != 7'd0) && (fits != 4'd0);
            end
        end
        job.chip_w = chip_w;
        job.chip_h = chip_h;
        job.cy0 = c0[15:0];
        job.cy3 = c3[15:0];
        job.fits = fits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mark_count_reg <= '0;
        else
            mark_count_reg <= mark_count_next;
    end
endmodule

### rtl/mlp_back.sv
// ----------------------------------------------------------------------------
// mlp_back: scans stored labels for all four candidates, BK_READ then BK_SCAN
// per label. Picks the first free candidate, stores it and emits the result beat.
// ----------------------------------------------------------------------------
module mlp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  mlp_pkg::job_t     job,
    output logic              job_take,
    output logic              done,
    output mlp_pkg::result_t  result
);
    import mlp_pkg::*;

    bk_state_t state_reg, state_next;
    job_t job_reg, job_next;
    logic [CntW-1:0] label_count_reg, label_count_next;
    logic [CntW-1:0] scan_reg, scan_next;
    logic [3:0] hit_reg, hit_next;
    logic [IdxW-1:0] raddr;
    logic [63:0] rdata;
    logic we;
    logic [63:0] wdata;
    logic [15:0] cy [4];
    logic [3:0] touch;
    logic [15:0] lx, ly, lw, lh;
    logic [3:0] free;
    logic [2:0] pick;
    logic [15:0] ptop;

    assign raddr = scan_reg[IdxW-1:0];

    mlp_ram #(.Width(64), .Depth(MaxMarks)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (label_count_reg[IdxW-1:0]),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        cy[0] = job_reg.cy0;
        cy[1] = 16'(job_reg.res.clip_y) + 16'(job_reg.res.clip_height) + 16'd1;
        cy[2] = {1'b0, job_reg.res.clip_y};
        cy[3] = job_reg.cy3;
        lx = rdata[15:0];
        ly = rdata[31:16];
        lw = rdata[47:32];
        lh = rdata[63:48];
        for (int k = 0; k < 4; k++)
        begin
            // candidates that fit are non-negative and inside 16 bits
            touch[k] = ({2'b0, job_reg.res.clip_x} < 17'(lx) + 17'(lw))
                && (17'(lx) < {2'b0, job_reg.res.clip_x} + 17'(job_reg.chip_w))
                && (17'(cy[k]) < 17'(ly) + 17'(lh))
                && (17'(ly) < 17'(cy[k]) + 17'(job_reg.chip_h));
        end
        free = job_reg.fits & ~hit_reg;
        pick = PosNone;
        ptop = '0;
        for (int k = 3; k >= 0; k--)
        begin
            if (free[k])
            begin
                pick = 3'(k + 1);
                ptop = cy[k];
            end
        end

        state_next = state_reg;
        job_next = job_reg;
        label_count_next = label_count_reg;
        scan_next = scan_reg;
        hit_next = hit_reg;
        job_take = 1'b0;
        done = 1'b0;
        we = 1'b0;
        wdata = {job_reg.chip_h, job_reg.chip_w, ptop, {1'b0, job_reg.res.clip_x}};
        result = job_reg.res;

        case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    job_take = 1'b1;
                    job_next = job;
                    scan_next = '0;
                    hit_next = '0;
                    if (job.clear)
                        label_count_next = '0;
                    state_next = job.try_label ? BK_READ : BK_DONE;
                end
            end
            BK_READ:
            begin
                // rdata for entry scan_reg lands next cycle
                state_next = BK_SCAN;
            end
            BK_SCAN:
            begin
                if (scan_reg >= label_count_reg)
                begin
                    state_next = BK_DONE;
                end
                else
                begin
                    hit_next = hit_reg | touch;
                    scan_next = scan_reg + 7'd1;
                    state_next = BK_READ;
                end
            end
            BK_DONE:
            begin
                done = 1'b1;
                if (job_reg.try_label && pick != PosNone)
                begin
                    result.label_position = pick;
                    result.label_top = ptop[14:0];
                    if (label_count_reg < 7'(MaxMarks))
                    begin
                        we = 1'b1;
                        label_count_next = label_count_reg + 7'd1;
                    end
                end
                state_next = BK_IDLE;
            end
            default:
                state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            label_count_reg <= '0;
            scan_reg <= '0;
            hit_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            label_count_reg <= label_count_next;
            scan_reg <= scan_next;
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end
endmodule

### rtl/mark_label_placement.sv
// ----------------------------------------------------------------------------
// mark_label_placement: numbered region marks with label chip placement
// Front clips and counts; back scans stored labels and places the chip.
// ----------------------------------------------------------------------------
//  channel   signals                                   handshake
//  input     start, busy, item                         start & !busy
//  result    result_valid, result                      one-cycle strobe
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid & cfg_ready
//
//  An item is written into the two-entry queue when it is taken, and the back
//  end takes it in BK_IDLE. An item that tries a label then passes a BK_READ
//  and a BK_SCAN for each of the N labels stored this frame (up to 64), plus
//  one final BK_READ and BK_SCAN, before BK_DONE; other items go straight to
//  BK_DONE. The result is registered from BK_DONE. busy is high while the
//  two-entry queue is full. Reset clears counts; label RAM needs no clearing.
//  Results cannot be stalled.
module mark_label_placement (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  mlp_pkg::item_t    item,
    output logic              result_valid,
    output mlp_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import mlp_pkg::*;

    logic [14:0] image_width_reg, image_height_reg;
    logic [4:0]  thick_reg;
    logic [6:0]  label_size_reg, mark_limit_reg;
    logic take, job_take, done;
    job_t front_job;
    job_t q_reg [QDepth];
    logic [QPtrW-1:0] wp_reg, rp_reg;
    logic [QCntW-1:0] cnt_reg;
    result_t res_reg;
    logic res_valid_reg;
    result_t bk_res;

    assign cfg_ready = 1'b1;
    assign busy = (cnt_reg == QCntW'(QDepth));
    assign take = start && !busy;

    mlp_front u_front (
        .clk(clk), .rst_n(rst_n), .take(take), .item(item),
        .image_width(image_width_reg), .image_height(image_height_reg),
        .line_thick(thick_reg), .label_size(label_size_reg),
        .mark_limit(mark_limit_reg), .job(front_job)
    );

    mlp_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(cnt_reg != '0), .job(q_reg[rp_reg]),
        .job_take(job_take), .done(done), .result(bk_res)
    );

    always_ff @(posedge clk)
    begin
        if (take)
            q_reg[wp_reg] <= front_job;
        res_reg <= bk_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
            res_valid_reg <= 1'b0;
            image_width_reg <= 15'd640;
            image_height_reg <= 15'd480;
            thick_reg <= 5'd2;
            label_size_reg <= 7'd12;
            mark_limit_reg <= 7'd64;
        end
        else
        begin
            if (take) wp_reg <= wp_reg + QPtrW'(1);
            if (job_take) rp_reg <= rp_reg + QPtrW'(1);
            cnt_reg <= cnt_reg + QCntW'(take) - QCntW'(job_take);
            res_valid_reg <= done;
            if (cfg_valid)
            begin
                case (cfg_index)
                    RegImageWidth:   image_width_reg <= cfg_data[14:0];
                    RegImageHeight:  image_height_reg <= cfg_data[14:0];
                    RegThickness:    thick_reg <= cfg_data[4:0];
                    RegLabelSize:    label_size_reg <= cfg_data[6:0];
                    RegMarkLimit:    mark_limit_reg <= cfg_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    assign result_valid = res_valid_reg;
    assign result = res_reg;

    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCntW'(QDepth)) else $error("queue overflow");
    a_no_take_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == QCntW'(QDepth)) |-> !take) else $error("take while full");
    a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> result_valid) else $error("lost result");
endmodule

### tb/sv/tb_mark_label_placement.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mark_label_placement: self-checking bench for mark label placement
// Feeds region boxes frame by frame under several register settings and
// idle patterns, predicts clip, outline, color and label chip placement in
// the bench, and compares every result beat field by field.
// ----------------------------------------------------------------------------
module tb_mark_label_placement;
    import mlp_pkg::*;

    localparam int WatchdogLimit = 4000;
    localparam int DrainCycles   = 160;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    item_t       item;
    logic        result_valid;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    mark_label_placement u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // shadow registers and frame state
    longint img_w, img_h, thick_set, lbl_set, marks_set;
    longint lab_x[MaxMarks], lab_y[MaxMarks], lab_w[MaxMarks], lab_h[MaxMarks];
    int     lbl_cnt, mk_cnt;

    item_t   region_q[$];
    result_t expected_marks[$];
    int      sender_idle;
    int      errors, items_sent, results_seen, flagged_seen, labels_seen;
    int      quiet_cycles;
    logic    taken;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic bit chips_touch(longint ax, longint ay, longint aw, longint ah,
                                       longint bx, longint by, longint bw, longint bh);
        return ax < bx + bw && bx < ax + aw && ay < by + bh && by < ay + ah;
    endfunction

    function automatic result_t place_mark(item_t it);
        result_t r;
        longint  bx, by, bw, bh, x0, y0, x1, y1, cw, ch, lh, scale, thk;
        longint  chip_w, chip_h, cy;
        longint  limit;
        bit      hit;
        r = '0;
        if (it.frame_start) begin
            lbl_cnt = 0;
            mk_cnt  = 0;
        end
        limit = marks_set < MaxMarks ? marks_set : MaxMarks;
        if (mk_cnt >= limit) begin
            r.over_budget = 1'b1;
            return r;
        end
        mk_cnt++;
        bx = longint'($signed(it.box_x));
        by = longint'($signed(it.box_y));
        bw = longint'($signed(it.box_width));
        bh = longint'($signed(it.box_height));
        x0 = bx > 0 ? bx : 0;
        y0 = by > 0 ? by : 0;
        x1 = (bx + bw) < img_w ? bx + bw : img_w;
        y1 = (by + bh) < img_h ? by + bh : img_h;
        cw = x1 - x0 > 0 ? x1 - x0 : 0;
        ch = y1 - y0 > 0 ? y1 - y0 : 0;
        lh = lbl_set > 64 ? 64 : lbl_set;
        scale = lh / 6 < 1 ? 1 : lh / 6;
        r.mark_number = mk_cnt[6:0];
        r.color_index = it.region_identity[2:0];
        r.label_scale = scale[3:0];
        if (cw > 0 && ch > 0) begin
            r.drawn       = 1'b1;
            r.clip_x      = x0[14:0];
            r.clip_y      = y0[14:0];
            r.clip_width  = cw[14:0];
            r.clip_height = ch[14:0];
            thk = thick_set < 1 ? 1 : (thick_set > 16 ? 16 : thick_set);
            if (cw < thk) thk = cw;
            if (ch < thk) thk = ch;
            r.outline_width = thk[4:0];
            if (lh > 0) begin
                chip_w = (mk_cnt >= 10 ? 2 : 1) * 3 * scale + 2;
                chip_h = 5 * scale + 2;
                for (int k = 0; k < 4; k++) begin
                    case (k)
                        0: cy = y0 - chip_h - 1;
                        1: cy = y0 + ch + 1;
                        2: cy = y0;
                        default: cy = y0 + ch - chip_h;
                    endcase
                    if (x0 < 0 || cy < 0 || x0 + chip_w > img_w || cy + chip_h > img_h)
                        continue;
                    hit = 1'b0;
                    for (int i = 0; i < lbl_cnt; i++)
                        if (chips_touch(x0, cy, chip_w, chip_h,
                                        lab_x[i], lab_y[i], lab_w[i], lab_h[i]))
                            hit = 1'b1;
                    if (hit)
                        continue;
                    r.label_position = 3'(k + 1);
                    r.label_top      = cy[14:0];
                    if (lbl_cnt < MaxMarks) begin
                        lab_x[lbl_cnt] = x0;
                        lab_y[lbl_cnt] = cy;
                        lab_w[lbl_cnt] = chip_w;
                        lab_h[lbl_cnt] = chip_h;
                        lbl_cnt++;
                    end
                    break;
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // monitor: input acceptance, result check, watchdog
    always @(posedge clk) begin
        result_t e;
        bit      active;
        if (rst_n) begin
            active = 1'b0;
            taken <= start && !busy;
            if (result_valid) begin
                active = 1'b1;
                results_seen++;
                if (expected_marks.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    errors++;
                end else begin
                    e = expected_marks.pop_front();
                    if (e.over_budget) flagged_seen++;
                    if (e.label_position != PosNone) labels_seen++;
                    check_field("mark_number", e.mark_number, result.mark_number);
                    check_field("drawn", e.drawn, result.drawn);
                    check_field("clip_x", e.clip_x, result.clip_x);
                    check_field("clip_y", e.clip_y, result.clip_y);
                    check_field("clip_width", e.clip_width, result.clip_width);
                    check_field("clip_height", e.clip_height, result.clip_height);
                    check_field("outline_width", e.outline_width, result.outline_width);
                    check_field("color_index", e.color_index, result.color_index);
                    check_field("label_position", e.label_position, result.label_position);
                    check_field("label_top", e.label_top, result.label_top);
                    check_field("label_scale", e.label_scale, result.label_scale);
                    check_field("over_budget", e.over_budget, result.over_budget);
                end
            end
            if (start && !busy) begin
                active = 1'b1;
                items_sent++;
                expected_marks.insert(expected_marks.size(), place_mark(item));
            end
            if (cfg_valid && cfg_ready)
                active = 1'b1;
            quiet_cycles <= active ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WatchdogLimit) begin
                $display("timeout: no beat accepted for %0d cycles", WatchdogLimit);
                $display("tb_mark_label_placement failed");
                $finish;
            end
        end
    end

    // driver: one assignment per signal per step
    always @(negedge clk) begin
        if (rst_n && (!start || taken)) begin
            if (region_q.size() != 0 && $urandom_range(99) >= sender_idle) begin
                start <= 1'b1;
                item  <= region_q.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            RegImageWidth:   img_w     = data & 32'h7fff;
            RegImageHeight:  img_h     = data & 32'h7fff;
            RegThickness:    thick_set = data & 32'h1f;
            RegLabelSize:    lbl_set   = data & 32'h7f;
            RegMarkLimit:    marks_set = data & 32'h7f;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_region(bit fs, int x, int y, int w, int h, longint unsigned id);
        item_t it;
        it.frame_start     = fs;
        it.box_x           = x;
        it.box_y           = y;
        it.box_width       = w;
        it.box_height      = h;
        it.region_identity = id;
        region_q.insert(region_q.size(), it);
    endtask

    function automatic longint unsigned rand_id();
        return {$urandom, $urandom};
    endfunction

    // one frame of mostly well-formed boxes, some noise and edge crossers
    task automatic add_frame(int n);
        int x, y, w, h, sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(19);
            if (sel == 0) begin
                add_region($urandom_range(1) == 0, $urandom, $urandom, $urandom, $urandom,
                           rand_id());
                continue;
            end
            x = int'($urandom_range(img_w + 20)) - 10;
            y = int'($urandom_range(img_h + 20)) - 10;
            w = $urandom_range(img_w / 3 + 2);
            h = $urandom_range(img_h / 3 + 2);
            if (sel == 1) w = -int'($urandom_range(5));
            if (sel == 2) h = 32'h7fff_ffff - y;
            if (sel == 3) x = 32'h8000_0000;
            add_region(i == 0, x, y, w, h, rand_id());
        end
    endtask

    task automatic settle();
        while (region_q.size() != 0 || start || expected_marks.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    initial begin
        int idles[6] = '{34, 34, 67, 67, 0, 0};
        int frame_len;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = RegImageWidth;
        cfg_data = '0;
        taken = 1'b0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        flagged_seen = 0;
        labels_seen = 0;
        quiet_cycles = 0;
        sender_idle = 0;
        lbl_cnt = 0;
        mk_cnt = 0;
        img_w = 640;
        img_h = 480;
        thick_set = 2;
        lbl_set = 12;
        marks_set = 64;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes of the fields and each placement outcome
        add_region(1, 10, 40, 50, 30, 64'd0);                // above
        add_region(0, 10, 0, 50, 30, 64'd1);                 // top edge: inside top
        add_region(0, 10, 0, 50, 470, 64'd2);                // inside bottom
        add_region(0, 10, 0, 50, 480, 64'd3);                // same spot, nothing fits
        add_region(0, 10, 0, 50, 480, 64'd4);                // nothing fits
        add_region(0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                   64'hffff_ffff_ffff_ffff);
        add_region(0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 64'd5);
        add_region(0, 100, 100, 0, 20, 64'd6);               // empty clip
        add_region(0, 100, 100, 20, 32'h8000_0000, 64'd7);
        add_region(0, 639, 479, 1, 1, 64'h8000_0000_0000_0000);
        add_region(0, -5, -5, 6, 6, 64'h5555_5555_5555_5555);
        add_region(0, 0, 0, 640, 480, 64'haaaa_aaaa_aaaa_aaaa);
        add_region(1, 300, 200, 1, 1, 64'd9);                // thin box, new frame
        for (int i = 0; i < 10; i++)
            add_region(0, 20 + 40 * i, 100, 30, 30, 64'(i));
        settle();
        write_reg(RegMarkLimit, 3);
        write_reg(RegLabelSize, 0);
        add_region(1, 5, 5, 20, 20, 64'd1);
        for (int i = 0; i < 4; i++)
            add_region(0, 5, 5, 20, 20, 64'd2);
        settle();

        for (int ph = 0; ph < 6; ph++) begin
            sender_idle = idles[ph];
            case (ph)
                0: begin
                    write_reg(RegImageWidth, 32767); write_reg(RegImageHeight, 32767);
                    write_reg(RegThickness, 16); write_reg(RegLabelSize, 64);
                    write_reg(RegMarkLimit, 64);
                end
                1: begin
                    write_reg(RegImageWidth, 1); write_reg(RegImageHeight, 1);
                    write_reg(RegThickness, 1); write_reg(RegLabelSize, 1);
                    write_reg(RegMarkLimit, 1);
                end
                2: begin
                    write_reg(RegImageWidth, 120); write_reg(RegImageHeight, 90);
                    write_reg(RegThickness, 0); write_reg(RegLabelSize, 127);
                    write_reg(RegMarkLimit, 127);
                end
                3: begin
                    write_reg(RegImageWidth, 200); write_reg(RegImageHeight, 150);
                    write_reg(RegThickness, 31); write_reg(RegLabelSize, 6);
                    write_reg(RegMarkLimit, 20);
                end
                4: begin
                    write_reg(RegImageWidth, 640); write_reg(RegImageHeight, 480);
                    write_reg(RegThickness, 3); write_reg(RegLabelSize, 12);
                    write_reg(RegMarkLimit, 0);
                end
                default: begin
                    write_reg(RegImageWidth, 320); write_reg(RegImageHeight, 240);
                    write_reg(RegThickness, 5); write_reg(RegLabelSize, 24);
                    write_reg(RegMarkLimit, 64);
                end
            endcase
            for (int n = 0; n < 240; n += frame_len) begin
                frame_len = $urandom_range(marks_set + 6, 1);
                if (frame_len > 70) frame_len = 70;
                add_frame(frame_len);
            end
            settle();
        end

        $display("covered %0d regions, %0d results: %0d labels placed, %0d over budget",
                 items_sent, results_seen, labels_seen, flagged_seen);
        $display("eight register settings, three sender idle patterns");
        if (errors == 0)
            $display("tb_mark_label_placement passed");
        else
            $display("tb_mark_label_placement failed");
        $finish;
    end

endmodule

### sim.f
rtl/mlp_pkg.sv
rtl/mlp_ram.sv
rtl/mlp_front.sv
rtl/mlp_back.sv
rtl/mark_label_placement.sv
tb/sv/tb_mark_label_placement.sv
